/* src/bfpa_pkg.sv */
package bfpa_pkg;

   // Field widths fixed by the request and result formats.
   localparam int SIZE_W            = 16;
   localparam int FREE_TOTAL_W      = 19;
   localparam int SLOT_FIELD_W      = 3;
   localparam int COUNT_W           = 3;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 16;
   localparam int MAX_SLOTS_DEFAULT = 6;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYSTEM_SIZE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PART_SIZE_0 = 3'd2;

   // Reset value of the slot count register.
   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 3'd6;

   // Request actions.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_ALLOC   = 3'd0,
      ST_FREED   = 3'd1,
      ST_EXCEEDS = 3'd2,
      ST_NOFIT   = 3'd3,
      ST_INVALID = 3'd4
   } status_type;

   typedef struct packed {
      logic                    action;
      logic [SIZE_W-1:0]       request_size;
      logic [SLOT_FIELD_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [SLOT_FIELD_W-1:0] chosen_slot;
      logic [SIZE_W-1:0]       waste;
      logic [FREE_TOTAL_W-1:0] free_total;
   } rsp_type;

endpackage

/* src/best_fit_partition_allocator.sv */
// Allocate: the request is checked against the free total, then each slot in use is
// scanned in turn before the result strobe; the next request waits until busy is low.
// One shared adder scans one partition per cycle. Free and refused-for-size requests
// skip the scan. A register write reloads the free total, with busy high meanwhile.
// Synchronous active-high reset: every slot free, free total 0, registers at defaults.
// Each result is shown for exactly one cycle; the receiver cannot stall it.
module best_fit_partition_allocator #(
   parameter int MAX_SLOTS = bfpa_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  bfpa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output bfpa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_en,
   input  logic [bfpa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bfpa_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int SW    = bfpa_pkg::SIZE_W;
   localparam int FW    = bfpa_pkg::FREE_TOTAL_W;
   localparam int CW    = bfpa_pkg::COUNT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT_BASE,
      S_INIT_SUM,
      S_CHECK,
      S_SCAN,
      S_COMMIT,
      S_FREE
   } state_type;

   state_type                  state_ff, state_in;
   logic [CW-1:0]              slot_count_ff, slot_count_in;
   logic [SW-1:0]              system_size_ff, system_size_in;
   logic [SW-1:0]              part_size_ff [MAX_SLOTS];
   logic [SW-1:0]              part_size_in [MAX_SLOTS];
   logic [SW-1:0]              held_size_ff [MAX_SLOTS];
   logic [SW-1:0]              held_size_in [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]       slot_busy_ff, slot_busy_in;
   logic [FW-1:0]              free_total_ff, free_total_in;
   bfpa_pkg::req_type          req_ff, req_in;
   logic [IDX_W-1:0]           cnt_ff, cnt_in;
   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           best_ff, best_in;
   logic [SW-1:0]              best_waste_ff, best_waste_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bfpa_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   // Slots in use, with the count clamped to the supported range.
   logic [CW-1:0] slots_used;
   logic          cnt_last;

   always_comb begin
      if (slot_count_ff == '0) begin
         slots_used = CW'(1);
      end else if (slot_count_ff > CW'(MAX_SLOTS)) begin
         slots_used = CW'(MAX_SLOTS);
      end else begin
         slots_used = slot_count_ff;
      end
   end

   assign cnt_last = (CW'(cnt_ff) == slots_used - CW'(1));

   // Free request decode: range check first, then the slot's busy bit.
   logic [IDX_W-1:0] free_idx;
   logic             free_ok;

   assign free_idx = req_ff.slot_index[IDX_W-1:0];
   assign free_ok  = (CW'(req_ff.slot_index) < slots_used) && slot_busy_ff[free_idx];

   // Shared add/subtract unit; its operands follow the sequencer state.
   logic [FW-1:0] alu_a, alu_b;
   logic          alu_sub;
   logic [FW:0]   alu_sum;
   logic          alu_borrow;

   always_comb begin
      alu_a   = free_total_ff;
      alu_b   = FW'(req_ff.request_size);
      alu_sub = 1'b1;
      unique case (state_ff)
         S_INIT_SUM: begin
            alu_b   = FW'(part_size_ff[cnt_ff]);
            alu_sub = 1'b0;
         end
         S_SCAN: begin
            alu_a = FW'(part_size_ff[cnt_ff]);
         end
         S_FREE: begin
            alu_b   = FW'(held_size_ff[free_idx]);
            alu_sub = 1'b0;
         end
         S_IDLE, S_INIT_BASE, S_CHECK, S_COMMIT: begin
         end
         default: begin
         end
      endcase
   end

   assign alu_sum    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (FW+1)'(alu_sub);
   assign alu_borrow = alu_sub & ~alu_sum[FW];

   // Register write decode; a write beyond the register list is dropped.
   logic csr_hit;

   always_comb begin
      csr_hit = 1'b0;
      if (csr_write_en) begin
         if (csr_index == bfpa_pkg::CSR_SLOT_COUNT || csr_index == bfpa_pkg::CSR_SYSTEM_SIZE) begin
            csr_hit = 1'b1;
         end
         for (int i = 0; i < MAX_SLOTS; i++) begin
            if (csr_index == bfpa_pkg::CSR_INDEX_W'(int'(bfpa_pkg::CSR_PART_SIZE_0) + i)) begin
               csr_hit = 1'b1;
            end
         end
      end
   end

   // Sequencer next-state and datapath updates.
   logic scan_fits;
   logic scan_better;

   assign scan_fits   = !slot_busy_ff[cnt_ff] && !alu_borrow;
   assign scan_better = !found_ff || (alu_sum[SW-1:0] < best_waste_ff);

   always_comb begin
      state_in       = state_ff;
      slot_count_in  = slot_count_ff;
      system_size_in = system_size_ff;
      part_size_in   = part_size_ff;
      held_size_in   = held_size_ff;
      slot_busy_in   = slot_busy_ff;
      free_total_in  = free_total_ff;
      req_in         = req_ff;
      cnt_in         = cnt_ff;
      found_in       = found_ff;
      best_in        = best_ff;
      best_waste_in  = best_waste_ff;
      rsp_valid_in   = 1'b0;
      rsp_data_in    = rsp_data_ff;

      if (csr_hit) begin
         // Any register write restarts the table and reloads the free total.
         if (csr_index == bfpa_pkg::CSR_SLOT_COUNT) begin
            slot_count_in = csr_data[CW-1:0];
         end else if (csr_index == bfpa_pkg::CSR_SYSTEM_SIZE) begin
            system_size_in = csr_data;
         end
         for (int i = 0; i < MAX_SLOTS; i++) begin
            if (csr_index == bfpa_pkg::CSR_INDEX_W'(int'(bfpa_pkg::CSR_PART_SIZE_0) + i)) begin
               part_size_in[i] = csr_data;
            end
         end
         slot_busy_in = '0;
         state_in     = S_INIT_BASE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_in = req_data;
                  state_in = (req_data.action == bfpa_pkg::ACT_FREE) ? S_FREE : S_CHECK;
               end
            end
            S_INIT_BASE: begin
               free_total_in = FW'(system_size_ff);
               cnt_in        = '0;
               state_in      = S_INIT_SUM;
            end
            S_INIT_SUM: begin
               free_total_in = alu_sum[FW-1:0];
               cnt_in        = cnt_ff + IDX_W'(1);
               if (cnt_last) begin
                  state_in = S_IDLE;
               end
            end
            S_CHECK: begin
               if (alu_borrow) begin
                  // Request larger than the free total.
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.status      = bfpa_pkg::ST_EXCEEDS;
                  rsp_data_in.chosen_slot = '0;
                  rsp_data_in.waste       = '0;
                  rsp_data_in.free_total  = free_total_ff;
                  state_in                = S_IDLE;
               end else begin
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
            S_SCAN: begin
               // One partition per cycle; strict compare keeps the lowest index on a tie.
               if (scan_fits && scan_better) begin
                  found_in      = 1'b1;
                  best_in       = cnt_ff;
                  best_waste_in = alu_sum[SW-1:0];
               end
               cnt_in = cnt_ff + IDX_W'(1);
               if (cnt_last) begin
                  state_in = S_COMMIT;
               end
            end
            S_COMMIT: begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (found_ff) begin
                  slot_busy_in[best_ff]   = 1'b1;
                  held_size_in[best_ff]   = req_ff.request_size;
                  free_total_in           = alu_sum[FW-1:0];
                  rsp_data_in.status      = bfpa_pkg::ST_ALLOC;
                  rsp_data_in.chosen_slot = bfpa_pkg::SLOT_FIELD_W'(best_ff);
                  rsp_data_in.waste       = best_waste_ff;
                  rsp_data_in.free_total  = alu_sum[FW-1:0];
               end else begin
                  rsp_data_in.status      = bfpa_pkg::ST_NOFIT;
                  rsp_data_in.chosen_slot = '0;
                  rsp_data_in.waste       = '0;
                  rsp_data_in.free_total  = free_total_ff;
               end
            end
            S_FREE: begin
               rsp_valid_in      = 1'b1;
               rsp_data_in.waste = '0;
               state_in          = S_IDLE;
               if (free_ok) begin
                  slot_busy_in[free_idx]  = 1'b0;
                  free_total_in           = alu_sum[FW-1:0];
                  rsp_data_in.status      = bfpa_pkg::ST_FREED;
                  rsp_data_in.chosen_slot = req_ff.slot_index;
                  rsp_data_in.free_total  = alu_sum[FW-1:0];
               end else begin
                  rsp_data_in.status      = bfpa_pkg::ST_INVALID;
                  rsp_data_in.chosen_slot = '0;
                  rsp_data_in.free_total  = free_total_ff;
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   // State, configuration and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         slot_count_ff  <= bfpa_pkg::SLOT_COUNT_RESET;
         system_size_ff <= '0;
         for (int i = 0; i < MAX_SLOTS; i++) begin
            part_size_ff[i] <= '0;
         end
         slot_busy_ff   <= '0;
         free_total_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         slot_count_ff  <= slot_count_in;
         system_size_ff <= system_size_in;
         part_size_ff   <= part_size_in;
         slot_busy_ff   <= slot_busy_in;
         free_total_ff  <= free_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      held_size_ff  <= held_size_in;
      req_ff        <= req_in;
      cnt_ff        <= cnt_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_waste_ff <= best_waste_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result strobe lasts one cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A result only follows a cycle of work.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in progress");

   // An accepted request makes the block busy.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // Error results carry no slot and no waste.
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == bfpa_pkg::ST_EXCEEDS
                     || rsp_data.status == bfpa_pkg::ST_NOFIT
                     || rsp_data.status == bfpa_pkg::ST_INVALID))
      |-> (rsp_data.chosen_slot == '0 && rsp_data.waste == '0))
      else $error("error result with nonzero slot or waste");

endmodule
